### rtl/ssp_pkg.sv
// shared types, codes and character helpers for the size string parser
// no dependencies; imported by every module of the block
`default_nettype none

package ssp_pkg;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // limit mode codes (the fourth code behaves as full range)
  localparam logic [1:0] LIM_FULL   = 2'd0;
  localparam logic [1:0] LIM_OFFSET = 2'd1;
  localparam logic [1:0] LIM_SIZE32 = 2'd2;

  // characters the parser looks for
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_UP_B  = 8'h42;
  localparam logic [7:0] CHR_UP_I  = 8'h49;
  localparam logic [7:0] CHR_LO_A  = 8'h61;
  localparam logic [7:0] CHR_LO_Z  = 8'h7A;

  // unit letters, upper case
  localparam logic [7:0] CHR_UP_K = 8'h4B;
  localparam logic [7:0] CHR_UP_M = 8'h4D;
  localparam logic [7:0] CHR_UP_G = 8'h47;
  localparam logic [7:0] CHR_UP_T = 8'h54;
  localparam logic [7:0] CHR_UP_P = 8'h50;
  localparam logic [7:0] CHR_UP_E = 8'h45;

  localparam logic [2:0] UNIT_NONE = 3'd7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } char_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
  } result_t;

  // parse state captured at the end of a string
  typedef struct packed {
    logic [63:0] acc;
    logic        digit_overflow;
    logic        negative;
    logic        seen_digit;
    logic        error;
    logic [7:0]  unit_letter;
  } ssp_snap_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHR_SPACE) || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= CHR_LO_A && c <= CHR_LO_Z) ? c - 8'h20 : c;
  endfunction

  // power of 1024 for a unit letter, UNIT_NONE if not a unit
  function automatic logic [2:0] unit_power(input logic [7:0] c);
    logic [7:0] u;
    logic [2:0] k;
    u = upper(c);
    unique case (u)
      CHR_UP_B: k = 3'd0;
      CHR_UP_K: k = 3'd1;
      CHR_UP_M: k = 3'd2;
      CHR_UP_G: k = 3'd3;
      CHR_UP_T: k = 3'd4;
      CHR_UP_P: k = 3'd5;
      CHR_UP_E: k = 3'd6;
      default:  k = UNIT_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/ssp_parser.sv
// character parser: walks the string one beat per cycle (while char_stall is low) and keeps the running state
// hands a snapshot of the state to the finisher on the last beat; uses ssp_pkg
`default_nettype none

module ssp_parser (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 char_valid,
  input  ssp_pkg::char_beat_t char_beat,
  input  wire                 char_stall,
  output ssp_pkg::ssp_snap_t  snap,
  output logic                snap_valid,
  input  wire                 snap_take
);
  import ssp_pkg::*;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_GAP    = 3'd3;
  localparam logic [2:0] PH_SUFFIX = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [63:0] acc, acc_next;
  logic        dovf, dovf_next;
  logic        neg, neg_next;
  logic        seen, seen_next;
  logic [7:0]  unit, unit_next;
  logic [1:0]  sfx, sfx_next;
  logic        err, err_next;

  logic        accept, ends;
  logic [7:0]  c, uc;
  logic        digit, ws, num_path, take_unit;
  logic [67:0] prod;

  assign accept = char_valid && !char_stall;
  assign c      = char_beat.char_code;
  assign ends   = (c == CHR_NUL) || char_beat.is_last;
  assign uc     = upper(c);
  assign digit  = (c >= CHR_ZERO) && (c <= CHR_NINE);
  assign ws     = is_ws(c);
  // acc * 10 + digit, carry bits above 64 mean overflow
  assign prod   = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {64'b0, c[3:0]};

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    dovf_next  = dovf;
    neg_next   = neg;
    seen_next  = seen;
    unit_next  = unit;
    sfx_next   = sfx;
    err_next   = err;
    num_path   = 1'b0;
    take_unit  = 1'b0;
    if (c != CHR_NUL && !err) begin
      unique case (phase) inside
        PH_LEAD: begin
          if (ws) begin
            phase_next = phase;
          end else if (c == CHR_PLUS || c == CHR_MINUS) begin
            neg_next   = (c == CHR_MINUS);
            phase_next = PH_SIGN;
          end else begin
            num_path = 1'b1;
          end
        end
        PH_SIGN, PH_DIGITS: num_path = 1'b1;
        PH_GAP: take_unit = !ws;
        PH_SUFFIX: begin
          if (ws) begin
            phase_next = PH_TRAIL;
          end else if (unit == CHR_UP_B) begin
            err_next = 1'b1;
          end else if (sfx == 2'd0 && uc == CHR_UP_I) begin
            sfx_next = 2'd1;
          end else if (sfx < 2'd2 && uc == CHR_UP_B) begin
            sfx_next = 2'd2;
          end else begin
            err_next = 1'b1;
          end
        end
        PH_TRAIL: err_next = !ws;
        default:  err_next = 1'b1;
      endcase

      if (num_path) begin
        if (digit) begin
          if (prod[67:64] != 4'd0) begin
            dovf_next = 1'b1;
            acc_next  = '1;
          end else begin
            acc_next  = prod[63:0];
          end
          seen_next  = 1'b1;
          phase_next = PH_DIGITS;
        end else if (phase != PH_DIGITS) begin
          err_next = 1'b1;
        end else if (ws) begin
          phase_next = PH_GAP;
        end else begin
          take_unit = 1'b1;
        end
      end

      if (take_unit) begin
        if (unit_power(c) == UNIT_NONE) begin
          err_next = 1'b1;
        end else begin
          unit_next  = c;
          sfx_next   = 2'd0;
          phase_next = PH_SUFFIX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && ends)) begin
      phase <= PH_LEAD;
      acc   <= '0;
      dovf  <= 1'b0;
      neg   <= 1'b0;
      seen  <= 1'b0;
      unit  <= '0;
      sfx   <= '0;
      err   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      acc   <= acc_next;
      dovf  <= dovf_next;
      neg   <= neg_next;
      seen  <= seen_next;
      unit  <= unit_next;
      sfx   <= sfx_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && ends) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ends) begin
      snap.acc            <= acc_next;
      snap.digit_overflow <= dovf_next;
      snap.negative       <= neg_next;
      snap.seen_digit     <= seen_next;
      snap.error          <= err_next;
      snap.unit_letter    <= unit_next;
    end
  end

  a_end_gives_snap: assert property (@(posedge clk) disable iff (rst)
    (accept && ends) |=> snap_valid)
    else $error("string end did not produce a snapshot");

  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    (accept && ends) |=> (phase == PH_LEAD && acc == 64'd0 && !err && !seen))
    else $error("parse state not cleared after string end");

endmodule

`default_nettype wire

### rtl/ssp_finish.sv
// finisher: applies sign, unit scaling and limit checks to a snapshot
// and holds the result beat until the receiver takes it; uses ssp_pkg
`default_nettype none

module ssp_finish (
  input  wire                clk,
  input  wire                rst,
  input  ssp_pkg::ssp_snap_t snap,
  input  wire                snap_valid,
  output logic               snap_take,
  input  wire  [1:0]         limit_mode,
  output ssp_pkg::result_t   result,
  output logic               result_valid,
  input  wire                result_stall
);
  import ssp_pkg::*;

  logic [63:0] v, shv;
  logic [2:0]  k;
  logic        ovf;
  result_t     res_next;

  assign snap_take = !result_valid || !result_stall;
  assign v = snap.negative ? (64'd0 - snap.acc) : snap.acc;
  assign k = (snap.unit_letter == CHR_NUL) ? 3'd0 : unit_power(snap.unit_letter);

  // scale by 1024^k, bits shifted out mean overflow
  always_comb begin
    unique case (k)
      3'd0: begin ovf = 1'b0;          shv = v;                 end
      3'd1: begin ovf = |v[63:54];     shv = {v[53:0], 10'b0};  end
      3'd2: begin ovf = |v[63:44];     shv = {v[43:0], 20'b0};  end
      3'd3: begin ovf = |v[63:34];     shv = {v[33:0], 30'b0};  end
      3'd4: begin ovf = |v[63:24];     shv = {v[23:0], 40'b0};  end
      3'd5: begin ovf = |v[63:14];     shv = {v[13:0], 50'b0};  end
      3'd6: begin ovf = |v[63:4];      shv = {v[3:0], 60'b0};   end
      default: begin ovf = 1'b0;       shv = v;                 end
    endcase
  end

  always_comb begin
    res_next.value = '0;
    if (snap.error || !snap.seen_digit) begin
      res_next.status = ST_MALFORMED;
    end else if (snap.digit_overflow) begin
      res_next.status = ST_RANGE;
    end else if (k == UNIT_NONE) begin
      res_next.status = ST_MALFORMED;
    end else if (ovf) begin
      res_next.status = ST_RANGE;
    end else if (limit_mode == LIM_OFFSET && shv[63]) begin
      res_next.status = ST_RANGE;
    end else if (limit_mode == LIM_SIZE32 && (shv[63:32] != 32'd0)) begin
      res_next.status = ST_RANGE;
    end else begin
      res_next.status = ST_OK;
      res_next.value  = shv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_take) begin
      result_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && snap_valid) begin
      result <= res_next;
    end
  end

  a_bad_status_zero_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |-> (result.value == 64'd0))
    else $error("non-ok result carries a nonzero value");

  a_snap_moves_out: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && snap_take) |=> result_valid)
    else $error("taken snapshot did not reach the result register");

endmodule

`default_nettype wire

### rtl/size_string_parser_top.sv
// top level of the size string parser: limit register, parser and finisher
// depends on ssp_pkg, ssp_parser and ssp_finish
//
// Usage: a size string such as " -12 KiB" is sent one character per beat
// on the char channel (char_valid, char_stall, char_beat). A string ends
// on a zero byte or on a beat with is_last set; that beat yields one beat
// on the result channel (result_valid, result_stall, result) carrying a
// status (ok, malformed, out of range) and the size in bytes.
// Throughput: one character beat per cycle while char_stall is low; strings
// may follow each other with no gap. The ending character's accepting edge
// loads the snapshot register, then the result register. The user must
// write the limit register with cfg_we / cfg_data only while the block is
// idle; the block itself does not enforce it.
// Reset (rst, synchronous) empties both registers stages, clears the parse
// state and sets full 64-bit range. When the receiver stalls, the result
// holds and one further finished string can wait in the snapshot stage;
// once that stage is full and cannot drain, char_stall is raised for
// every character beat until the result moves on.
`default_nettype none

module size_string_parser_top (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_data,
  input  wire                 char_valid,
  output logic                char_stall,
  input  ssp_pkg::char_beat_t char_beat,
  output logic                result_valid,
  input  wire                 result_stall,
  output ssp_pkg::result_t    result
);
  import ssp_pkg::*;

  logic [1:0] limit_mode;
  ssp_snap_t  snap;
  logic       snap_valid;
  logic       snap_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_mode <= LIM_FULL;
    end else if (cfg_we) begin
      limit_mode <= cfg_data;
    end
  end

  // the snapshot stage is full and cannot drain
  assign char_stall = snap_valid && !snap_take;

  ssp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_beat  (char_beat),
    .char_stall (char_stall),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_take  (snap_take)
  );

  ssp_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .snap         (snap),
    .snap_valid   (snap_valid),
    .snap_take    (snap_take),
    .limit_mode   (limit_mode),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench for size_string_parser_top: streams size strings one character beat
// at a time, predicts each result beat in-line and checks it; depends on ssp_pkg
`timescale 1ns / 1ps

module tb_top;
  import ssp_pkg::*;

  // the fourth limit code has no name in the package; the block treats it as full range
  localparam logic [1:0] LIM_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [63:0] TEN_LIMIT = 64'd1844674407370955161;

  typedef enum logic [2:0] {
    SCAN_LEAD, SCAN_SIGN, SCAN_DIGITS, SCAN_GAP, SCAN_UNIT, SCAN_TAIL
  } scan_phase_e;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = LIM_FULL;
  logic       char_valid = 1'b0;
  logic       char_stall;
  char_beat_t char_beat = '0;
  logic       result_valid;
  logic       result_stall;
  result_t    result;

  size_string_parser_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_beat    (char_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // predictor state
  scan_phase_e scan_phase;
  logic [63:0] scan_acc;
  logic        scan_ovf;
  logic        scan_neg;
  logic        scan_digits;
  logic [7:0]  scan_unit;
  logic [1:0]  scan_sfx;
  logic        scan_bad;
  logic [1:0]  limit_reg = LIM_FULL;

  result_t     parsed_sizes_q[$];
  result_t     due;
  logic [7:0]  line_q[$];
  int          fail_count = 0;
  int          beats_sent = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_space(input logic [7:0] c);
    return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return (c >= CHR_LO_A && c <= CHR_LO_Z) ? c - 8'h20 : c;
  endfunction

  // power of 1024 for a unit letter, -1 when not a unit
  function automatic int unit_shift(input logic [7:0] c);
    case (fold_upper(c))
      CHR_UP_B: return 0;
      CHR_UP_K: return 1;
      CHR_UP_M: return 2;
      CHR_UP_G: return 3;
      CHR_UP_T: return 4;
      CHR_UP_P: return 5;
      CHR_UP_E: return 6;
      default:  return -1;
    endcase
  endfunction

  function automatic void clear_parse();
    scan_phase  = SCAN_LEAD;
    scan_acc    = '0;
    scan_ovf    = 1'b0;
    scan_neg    = 1'b0;
    scan_digits = 1'b0;
    scan_unit   = CHR_NUL;
    scan_sfx    = 2'd0;
    scan_bad    = 1'b0;
  endfunction

  function automatic void take_unit(input logic [7:0] c);
    if (unit_shift(c) < 0) begin
      scan_bad = 1'b1;
    end else begin
      scan_unit  = c;
      scan_sfx   = 2'd0;
      scan_phase = SCAN_UNIT;
    end
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - CHR_ZERO);
    if (scan_bad) return;
    if (scan_phase == SCAN_LEAD && is_space(c)) begin
    end else if (scan_phase == SCAN_LEAD && (c == CHR_PLUS || c == CHR_MINUS)) begin
      scan_neg   = (c == CHR_MINUS);
      scan_phase = SCAN_SIGN;
    end else if (scan_phase == SCAN_LEAD || scan_phase == SCAN_SIGN ||
                 scan_phase == SCAN_DIGITS) begin
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
        if (scan_acc > TEN_LIMIT || (scan_acc == TEN_LIMIT && d > 64'd5)) begin
          scan_ovf = 1'b1;
          scan_acc = '1;
        end else begin
          scan_acc = scan_acc * 64'd10 + d;
        end
        scan_digits = 1'b1;
        scan_phase  = SCAN_DIGITS;
      end else if (scan_phase != SCAN_DIGITS) begin
        scan_bad = 1'b1;
      end else if (is_space(c)) begin
        scan_phase = SCAN_GAP;
      end else begin
        take_unit(c);
      end
    end else begin
      case (scan_phase)
        SCAN_GAP: if (!is_space(c)) take_unit(c);
        SCAN_UNIT: begin
          if (is_space(c)) scan_phase = SCAN_TAIL;
          else if (scan_unit == CHR_UP_B) scan_bad = 1'b1;
          else if (scan_sfx == 2'd0 && fold_upper(c) == CHR_UP_I) scan_sfx = 2'd1;
          else if (scan_sfx < 2'd2 && fold_upper(c) == CHR_UP_B) scan_sfx = 2'd2;
          else scan_bad = 1'b1;
        end
        SCAN_TAIL: if (!is_space(c)) scan_bad = 1'b1;
        default: scan_bad = 1'b1;
      endcase
    end
  endfunction

  // one accepted character beat; a string end queues the size it should produce
  function automatic void parse_size_byte(input logic [7:0] c, input logic last);
    result_t     r;
    logic [63:0] v;
    int          k;
    if (c != CHR_NUL) absorb_char(c);
    if (c != CHR_NUL && !last) return;
    r.status = ST_OK;
    r.value  = '0;
    if (scan_bad || !scan_digits) begin
      r.status = ST_MALFORMED;
    end else if (scan_ovf) begin
      r.status = ST_RANGE;
    end else begin
      v = scan_neg ? -scan_acc : scan_acc;
      k = (scan_unit == CHR_NUL) ? 0 : unit_shift(scan_unit);
      if (k > 0 && v > (64'hFFFF_FFFF_FFFF_FFFF >> (10 * k))) begin
        r.status = ST_RANGE;
      end else begin
        v = v << (10 * k);
        if (limit_reg == LIM_OFFSET && v > 64'h7FFF_FFFF_FFFF_FFFF) r.status = ST_RANGE;
        else if (limit_reg == LIM_SIZE32 && v > 64'hFFFF_FFFF) r.status = ST_RANGE;
        else r.value = v;
      end
    end
    parsed_sizes_q.push_back(r);
    clear_parse();
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (parsed_sizes_q.size() == 0) begin
        $error("unexpected result beat: status %0d value %0d", result.status, result.value);
        fail_count++;
      end else begin
        due = parsed_sizes_q.pop_front();
        if (result.status !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, result.status);
          fail_count++;
        end
        if (result.value !== due.value) begin
          $error("value: expected %0d, actual %0d", due.value, result.value);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int style;
    int left;
    style = 0;
    left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_stall <= 1'b1;
        hold_cycles--;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (style)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= 1'($urandom_range(0, 1));
          default: result_stall <= (left % 7 < 4);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_char(input logic [7:0] c, input logic last);
    char_beat_t nb;
    nb.char_code = c;
    nb.is_last = last;
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    char_valid <= 1'b1;
    char_beat <= nb;
    do @(posedge clk); while (char_stall);
    beats_sent++;
    parse_size_byte(c, last);
  endtask

  // send the buffered string, ended by is_last on its final beat or by a zero byte
  task automatic ship_line(input logic nul_end);
    int n;
    n = line_q.size();
    for (int i = 0; i < n; i++) send_char(line_q[i], !nul_end && i == n - 1);
    if (nul_end || n == 0) send_char(CHR_NUL, 1'($urandom_range(0, 1)));
    line_q.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic put_space();
    int w;
    w = $urandom_range(0, 5);
    line_q.push_back(w == 5 ? CHR_SPACE : 8'(CHR_TAB + w));
  endtask

  task automatic put_letter(input logic [7:0] up);
    line_q.push_back($urandom_range(0, 1) ? up : up + 8'h20);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    char_valid <= 1'b0;
    while (parsed_sizes_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [1:0] mode);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_reg = mode;
  endtask

  task automatic build_random_line();
    int          sel;
    int          n;
    logic [63:0] v;
    string       units;
    units = "BKMGTPE";
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) put_space();
    case ($urandom_range(0, 4))
      0: line_q.push_back(CHR_PLUS);
      1: line_q.push_back(CHR_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) line_q.push_back(CHR_ZERO);
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3, 4: v = 64'($urandom_range(0, 9999));
      5, 6: v = {$urandom, $urandom};
      7: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      8: begin
        case ($urandom_range(0, 3))
          0: v = 64'hFFFF_FFFF;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = 64'h3F_FFFF;
          default: v = 64'h1F;
        endcase
        v = v - 64'd1 + 64'($urandom_range(0, 2));
      end
      default: v = '0;
    endcase
    if (sel == 9) begin
      // long digit runs around and past the 64-bit limit
      line_q.push_back(8'(CHR_ZERO + $urandom_range(1, 9)));
      repeat ($urandom_range(19, 21)) line_q.push_back(8'(CHR_ZERO + $urandom_range(0, 9)));
    end else begin
      put_text($sformatf("%0d", v));
    end
    if ($urandom_range(0, 3) == 0) put_space();
    if ($urandom_range(0, 9) >= 3) begin
      put_letter(units[$urandom_range(0, 6)]);
      case ($urandom_range(0, 4))
        2: put_letter(CHR_UP_I);
        3: begin
          put_letter(CHR_UP_I);
          put_letter(CHR_UP_B);
        end
        4: put_letter(CHR_UP_B);
        default: ;
      endcase
    end
    repeat ($urandom_range(0, 2)) put_space();
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(0, 2))
        0: line_q[n] = 8'($urandom_range(1, 255));
        1: if (n == 0) line_q.delete(); else line_q = line_q[0:n-1];
        default: line_q.insert(n, 8'($urandom_range(1, 255)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_forms();
    put_text("0");                      ship_line(1'b0);
    put_text("18446744073709551615");   ship_line(1'b0);
    put_text("18446744073709551616");   ship_line(1'b1);
    put_text("-99999999999999999999");  ship_line(1'b0);
    line_q.push_back(CHR_TAB);
    line_q.push_back(8'h0B);
    line_q.push_back(8'h0C);
    put_text("-1");                     ship_line(1'b0);
    ship_line(1'b1);                    // empty string
    put_text("  ");
    line_q.push_back(CHR_CR);           ship_line(1'b1);
    put_text("+");                      ship_line(1'b0);
    put_text("12x");                    ship_line(1'b0);
    put_text("99999999999999999999q");  ship_line(1'b1);  // malformed beats overflow
    put_text("1x2 K");                  ship_line(1'b0);  // bytes after the error are ignored
    put_text("5B");                     ship_line(1'b0);
    put_text("5Bi");                    ship_line(1'b0);
    put_text("5bi");                    ship_line(1'b0);
    put_text("7 k");                    ship_line(1'b1);
    put_text("+3MiB");                  ship_line(1'b0);
    put_text("2gB  ");
    line_q.push_back(8'h0A);            ship_line(1'b0);
    put_text("1Ti");                    ship_line(1'b0);
    put_text("1P");                     ship_line(1'b0);
    put_text("15E");                    ship_line(1'b0);
    put_text("16e");                    ship_line(1'b0);
    put_text("1KBi");                   ship_line(1'b0);
    put_text("1 K x");                  ship_line(1'b0);
    put_text("1-");                     ship_line(1'b0);
    line_q.push_back(8'hFF);            ship_line(1'b0);
    put_text("4");
    line_q.push_back(8'h80);            ship_line(1'b1);
  endtask

  task automatic test_limit_bounds();
    string offset_cases[$];
    string size_cases[$];
    string spare_cases[$];
    offset_cases = '{"9223372036854775807", "9223372036854775808", "7E", "8E", "-1", "-0"};
    size_cases   = '{"4294967295", "4294967296", "4194303K", "4G", "-1", "3gib"};
    spare_cases  = '{"-1", "16E", "18446744073709551615", "8E"};
    set_limit(LIM_OFFSET);
    foreach (offset_cases[i]) begin
      put_text(offset_cases[i]);
      ship_line(1'($urandom_range(0, 1)));
    end
    set_limit(LIM_SIZE32);
    foreach (size_cases[i]) begin
      put_text(size_cases[i]);
      ship_line(1'($urandom_range(0, 1)));
    end
    set_limit(LIM_SPARE);
    foreach (spare_cases[i]) begin
      put_text(spare_cases[i]);
      ship_line(1'($urandom_range(0, 1)));
    end
    set_limit(LIM_FULL);
  endtask

  // receiver holds off while short strings keep coming, so the input stalls
  task automatic test_result_holdoff();
    gaps_on = 1'b0;
    hold_cycles = 400;
    repeat (40) begin
      if ($urandom_range(0, 1)) put_text("7");
      else build_random_line();
      ship_line(1'($urandom_range(0, 1)));
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_strings();
    int start;
    start = beats_sent;
    while (beats_sent - start < 1250) begin
      if ($urandom_range(0, 29) == 0) set_limit(2'($urandom_range(0, 3)));
      if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
      build_random_line();
      ship_line(1'($urandom_range(0, 1)));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_parse();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_forms();
    test_limit_bounds();
    test_result_holdoff();
    test_random_strings();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
rtl/ssp_pkg.sv
rtl/ssp_parser.sv
rtl/ssp_finish.sv
rtl/size_string_parser_top.sv
tb/tb_top.sv
